// ===== hw/rtl/dfs_pkg.sv =====
// ============================================================================
// dfs_pkg
// Shared widths, register indexes, types and helpers for the diagonal
// fragment scanner.
// ============================================================================
`default_nettype none

package dfs_pkg;

    // Field widths
    localparam int POS_W   = 16;
    localparam int DOT_W   = 16;
    localparam int CFG_W   = 24;
    localparam int SCORE_W = 32;
    localparam int CNT_W   = 16;
    localparam int DIAG_W  = POS_W + 1;
    localparam int IDX_W   = 2;

    // One axis: 24-bit open plus (17-bit distance x 24-bit extend)
    localparam int AXIS_W  = 42;
    // Row and column cost together
    localparam int GAP_W   = AXIS_W + 1;
    // Running score + dot score + gap cost before saturation
    localparam int SUM_W   = GAP_W + 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_ROW_GAP_OPEN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROW_GAP_EXTEND = 2'd1;
    localparam logic [IDX_W-1:0] REG_COL_GAP_OPEN   = 2'd2;
    localparam logic [IDX_W-1:0] REG_COL_GAP_EXTEND = 2'd3;

    typedef struct packed {
        logic signed [CFG_W-1:0] row_gap_open;
        logic signed [CFG_W-1:0] row_gap_extend;
        logic signed [CFG_W-1:0] col_gap_open;
        logic signed [CFG_W-1:0] col_gap_extend;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]          row_start;
        logic [POS_W-1:0]          col_start;
        logic [POS_W-1:0]          row_end;
        logic [POS_W-1:0]          col_end;
        logic signed [SCORE_W-1:0] score;
        logic [CNT_W-1:0]          length;
    } frag_t;

    // Clamp a wide sum into the signed score range
    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [SUM_W-1:0] x
    );
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &x[SUM_W-1:SCORE_W-1];
        hi_zeros = ~|x[SUM_W-1:SCORE_W-1];
        if (hi_ones || hi_zeros) begin
            sat_score = x[SCORE_W-1:0];
        end else if (x[SUM_W-1]) begin
            sat_score = {1'b1, {(SCORE_W-1){1'b0}}};
        end else begin
            sat_score = {1'b0, {(SCORE_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dfs_gap_cost.sv =====
// ============================================================================
// dfs_gap_cost
// Affine gap cost between a dot and the previous kept dot, row and column.
// ============================================================================
`default_nettype none

module dfs_gap_cost (
    input  wire logic [dfs_pkg::POS_W-1:0]          row,
    input  wire logic [dfs_pkg::POS_W-1:0]          col,
    input  wire logic [dfs_pkg::POS_W-1:0]          prev_row,
    input  wire logic [dfs_pkg::POS_W-1:0]          prev_col,
    input  wire logic                               prev_valid,
    input  wire dfs_pkg::cfg_t                      cfg,
    output logic signed [dfs_pkg::GAP_W-1:0]        gap
);

    localparam int PW = dfs_pkg::POS_W;
    localparam int CW = dfs_pkg::CFG_W;
    localparam int AW = dfs_pkg::AXIS_W;
    localparam int DW = PW + 2;
    localparam int MW = PW + 1 + CW;

    // Cost of one axis: open + skipped * extend when positions skip ahead
    function automatic logic signed [AW-1:0] axis_cost(
        input logic [PW-1:0]        pos,
        input logic [PW-1:0]        prev,
        input logic signed [CW-1:0] open_c,
        input logic signed [CW-1:0] ext_c
    );
        logic signed [DW-1:0] span;
        logic signed [MW-1:0] prod;
        span = $signed({2'b00, pos}) - $signed({2'b00, prev}) - $signed(DW'(1));
        prod = $signed({1'b0, span[PW-1:0]}) * ext_c;
        if (!span[DW-1] && (span != '0)) begin
            axis_cost = {{(AW-CW){open_c[CW-1]}}, open_c}
                      + {{(AW-MW){prod[MW-1]}}, prod};
        end else begin
            axis_cost = '0;
        end
    endfunction

    logic signed [AW-1:0] row_cost;
    logic signed [AW-1:0] col_cost;

    // Sum both axes; no cost without a previous dot
    always_comb begin
        row_cost = axis_cost(row, prev_row, cfg.row_gap_open, cfg.row_gap_extend);
        col_cost = axis_cost(col, prev_col, cfg.col_gap_open, cfg.col_gap_extend);
        if (prev_valid) begin
            gap = {row_cost[AW-1], row_cost} + {col_cost[AW-1], col_cost};
        end else begin
            gap = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dfs_fragment_track.sv =====
// ============================================================================
// dfs_fragment_track
// Running diagonal state: scores each dot, closes fragments, reports one.
// ============================================================================
`default_nettype none

module dfs_fragment_track (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               step,
    input  wire logic [dfs_pkg::POS_W-1:0]          dot_row,
    input  wire logic [dfs_pkg::POS_W-1:0]          dot_col,
    input  wire logic signed [dfs_pkg::DOT_W-1:0]   dot_score,
    input  wire logic                               final_dot,
    input  wire dfs_pkg::cfg_t                      cfg,
    output logic                                    frag_hit,
    output dfs_pkg::frag_t                          frag
);

    localparam int PW = dfs_pkg::POS_W;
    localparam int SW = dfs_pkg::SCORE_W;
    localparam int NW = dfs_pkg::CNT_W;
    localparam int XW = dfs_pkg::DIAG_W;
    localparam int GW = dfs_pkg::GAP_W;
    localparam int UW = dfs_pkg::SUM_W;
    localparam int DTW = dfs_pkg::DOT_W;

    // State registers
    logic                 diag_known_reg,    diag_known_next;
    logic [XW-1:0]        cur_diag_reg,      cur_diag_next;
    logic                 prev_valid_reg,    prev_valid_next;
    logic [PW-1:0]        prev_row_reg,      prev_row_next;
    logic [PW-1:0]        prev_col_reg,      prev_col_next;
    logic [PW-1:0]        start_row_reg,     start_row_next;
    logic [PW-1:0]        start_col_reg,     start_col_next;
    logic signed [SW-1:0] score_reg,         score_next;
    logic [NW-1:0]        count_reg,         count_next;

    logic [XW-1:0]        diag;
    logic                 diag_change;
    logic                 eff_pv;
    logic signed [SW-1:0] eff_score;
    logic [NW-1:0]        eff_count;
    logic signed [GW-1:0] gap;
    logic signed [UW-1:0] sum;
    logic signed [SW-1:0] nscore;
    logic                 npos;
    logic                 dot_pos;
    logic                 old_ok;
    logic                 rep_old;
    logic                 rep_new;

    // Restart on a new diagonal
    always_comb begin
        diag        = {1'b0, dot_col} - {1'b0, dot_row};
        diag_change = !diag_known_reg || (diag != cur_diag_reg);
        eff_pv      = prev_valid_reg && !diag_change;
        eff_score   = diag_change ? '0 : score_reg;
        eff_count   = diag_change ? '0 : count_reg;
    end

    dfs_gap_cost u_gap (
        .row        (dot_row),
        .col        (dot_col),
        .prev_row   (prev_row_reg),
        .prev_col   (prev_col_reg),
        .prev_valid (eff_pv),
        .cfg        (cfg),
        .gap        (gap)
    );

    // Score the dot and decide what closes
    always_comb begin
        sum = {{(UW-SW){eff_score[SW-1]}}, eff_score}
            + {{(UW-DTW){dot_score[DTW-1]}}, dot_score}
            + {{(UW-GW){gap[GW-1]}}, gap};
        nscore  = dfs_pkg::sat_score(sum);
        npos    = !nscore[SW-1] && (nscore != '0);
        dot_pos = !dot_score[DTW-1] && (dot_score != '0);
        old_ok  = !score_reg[SW-1] && (score_reg != '0) && (count_reg > NW'(1));
        rep_old = old_ok && (diag_change || !npos);
    end

    // Next state of the open fragment
    always_comb begin
        prev_valid_next = prev_valid_reg;
        prev_row_next   = prev_row_reg;
        prev_col_next   = prev_col_reg;
        start_row_next  = start_row_reg;
        start_col_next  = start_col_reg;
        score_next      = score_reg;
        count_next      = count_reg;
        if (!npos) begin
            if (dot_pos) begin
                prev_valid_next = 1'b1;
                prev_row_next   = dot_row;
                prev_col_next   = dot_col;
                start_row_next  = dot_row;
                start_col_next  = dot_col;
                score_next      = {{(SW-DTW){dot_score[DTW-1]}}, dot_score};
                count_next      = NW'(1);
            end else begin
                prev_valid_next = 1'b0;
                score_next      = '0;
                count_next      = '0;
            end
        end else begin
            if (eff_count == '0) begin
                start_row_next = dot_row;
                start_col_next = dot_col;
            end
            prev_valid_next = 1'b1;
            prev_row_next   = dot_row;
            prev_col_next   = dot_col;
            score_next      = nscore;
            count_next      = (eff_count == dfs_pkg::COUNT_MAX) ? eff_count
                                                               : eff_count + NW'(1);
        end
        diag_known_next = 1'b1;
        cur_diag_next   = diag;
        rep_new         = final_dot && !rep_old && npos && (count_next > NW'(1));
    end

    // Pick the closed fragment: the old one, or the one flushed by the final dot
    always_comb begin
        frag_hit = rep_old || rep_new;
        if (rep_old) begin
            frag.row_start = start_row_reg;
            frag.col_start = start_col_reg;
            frag.row_end   = prev_row_reg;
            frag.col_end   = prev_col_reg;
            frag.score     = score_reg;
            frag.length    = count_reg;
        end else begin
            frag.row_start = start_row_next;
            frag.col_start = start_col_next;
            frag.row_end   = prev_row_next;
            frag.col_end   = prev_col_next;
            frag.score     = score_next;
            frag.length    = count_next;
        end
    end

    // Advance state; the final dot drops everything
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && final_dot)) begin
            diag_known_reg <= 1'b0;
            cur_diag_reg   <= '0;
            prev_valid_reg <= 1'b0;
            prev_row_reg   <= '0;
            prev_col_reg   <= '0;
            start_row_reg  <= '0;
            start_col_reg  <= '0;
            score_reg      <= '0;
            count_reg      <= '0;
        end else if (step) begin
            diag_known_reg <= diag_known_next;
            cur_diag_reg   <= cur_diag_next;
            prev_valid_reg <= prev_valid_next;
            prev_row_reg   <= prev_row_next;
            prev_col_reg   <= prev_col_next;
            start_row_reg  <= start_row_next;
            start_col_reg  <= start_col_next;
            score_reg      <= score_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/diagonal_fragment_scanner_unit.sv =====
// ============================================================================
// diagonal_fragment_scanner_unit
// Splits a stream of dot-plot dots into scored diagonal fragments.
// ============================================================================
// Usage:
//   Dots enter on the s_ channel (valid/ready), sorted by diagonal and then
//   by row; s_final_dot marks the last dot of a stream and flushes the open
//   fragment. Each dot yields zero or one fragment word on the m_ channel.
//   Gap costs are set through the cfg_ write port (four 24-bit registers,
//   indexed by cfg_index) while no dot is in flight.
// Path: an accepted dot waits in the input register; its fragment is then
//   registered in the result register once that register is free.
// Throughput: one dot per cycle while fragment words are taken. The running
//   score feeds back combinationally: gap multiply, three-way add, saturate
//   and compare sit between the input register and state/result registers.
// Stall: while a fragment word waits on m_ready the input register still
//   takes one more dot; further dots wait until the result is taken.
// Reset: aresetn (synchronous, active low) empties both registers, drops the
//   open fragment and clears all gap costs to zero.
// ============================================================================
`default_nettype none

module diagonal_fragment_scanner_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [dfs_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [dfs_pkg::CFG_W-1:0]           cfg_wdata,
    // Dot input
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [dfs_pkg::POS_W-1:0]           s_dot_row,
    input  wire logic [dfs_pkg::POS_W-1:0]           s_dot_col,
    input  wire logic signed [dfs_pkg::DOT_W-1:0]    s_dot_score,
    input  wire logic                                s_final_dot,
    // Fragment output
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [dfs_pkg::POS_W-1:0]                m_frag_row_start,
    output logic [dfs_pkg::POS_W-1:0]                m_frag_col_start,
    output logic [dfs_pkg::POS_W-1:0]                m_frag_row_end,
    output logic [dfs_pkg::POS_W-1:0]                m_frag_col_end,
    output logic signed [dfs_pkg::SCORE_W-1:0]       m_frag_score,
    output logic [dfs_pkg::CNT_W-1:0]                m_frag_length
);

    dfs_pkg::cfg_t cfg_reg;

    logic                                   in_valid_reg, in_valid_next;
    logic [dfs_pkg::POS_W-1:0]              in_row_reg;
    logic [dfs_pkg::POS_W-1:0]              in_col_reg;
    logic signed [dfs_pkg::DOT_W-1:0]       in_score_reg;
    logic                                   in_final_reg;

    logic                                   out_valid_reg, out_valid_next;
    dfs_pkg::frag_t                         out_frag_reg;

    logic                                   step;
    logic                                   s_take;
    logic                                   frag_hit;
    dfs_pkg::frag_t                         frag;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dfs_pkg::REG_ROW_GAP_OPEN:   cfg_reg.row_gap_open   <= cfg_wdata;
                dfs_pkg::REG_ROW_GAP_EXTEND: cfg_reg.row_gap_extend <= cfg_wdata;
                dfs_pkg::REG_COL_GAP_OPEN:   cfg_reg.col_gap_open   <= cfg_wdata;
                dfs_pkg::REG_COL_GAP_EXTEND: cfg_reg.col_gap_extend <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Handshake: process the held dot when the result register is free
    always_comb begin
        step           = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready        = !in_valid_reg || step;
        s_take         = s_valid && s_ready;
        in_valid_next  = s_take ? 1'b1 : (step ? 1'b0 : in_valid_reg);
        out_valid_next = step ? frag_hit : (m_ready ? 1'b0 : out_valid_reg);
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_row_reg   <= s_dot_row;
            in_col_reg   <= s_dot_col;
            in_score_reg <= s_dot_score;
            in_final_reg <= s_final_dot;
        end
    end

    dfs_fragment_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .dot_row   (in_row_reg),
        .dot_col   (in_col_reg),
        .dot_score (in_score_reg),
        .final_dot (in_final_reg),
        .cfg       (cfg_reg),
        .frag_hit  (frag_hit),
        .frag      (frag)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && frag_hit) begin
            out_frag_reg <= frag;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frag_row_start = out_frag_reg.row_start;
    assign m_frag_col_start = out_frag_reg.col_start;
    assign m_frag_row_end   = out_frag_reg.row_end;
    assign m_frag_col_end   = out_frag_reg.col_end;
    assign m_frag_score     = out_frag_reg.score;
    assign m_frag_length    = out_frag_reg.length;

endmodule

`default_nettype wire

// ===== hw/rtl/dfs_checker.sv =====
// ============================================================================
// dfs_checker
// Port-level checks on the fragment scanner, bound to the top level.
// ============================================================================
`default_nettype none

module dfs_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [dfs_pkg::POS_W-1:0]           m_frag_row_start,
    input  wire logic [dfs_pkg::POS_W-1:0]           m_frag_col_start,
    input  wire logic [dfs_pkg::POS_W-1:0]           m_frag_row_end,
    input  wire logic [dfs_pkg::POS_W-1:0]           m_frag_col_end,
    input  wire logic signed [dfs_pkg::SCORE_W-1:0]  m_frag_score,
    input  wire logic [dfs_pkg::CNT_W-1:0]           m_frag_length
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("fragment word present after reset");

    // A stalled word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_frag_row_start)
            && $stable(m_frag_col_start) && $stable(m_frag_row_end)
            && $stable(m_frag_col_end) && $stable(m_frag_score)
            && $stable(m_frag_length)))
        else $error("stalled fragment word changed");

    // Only fragments of two or more dots are reported
    a_min_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frag_length > dfs_pkg::CNT_W'(1)))
        else $error("fragment shorter than two dots");

    // Only positive scores are reported
    a_pos_score: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frag_score > 0))
        else $error("fragment with non-positive score");

endmodule

bind diagonal_fragment_scanner_unit dfs_checker u_dfs_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_frag_row_start (m_frag_row_start),
    .m_frag_col_start (m_frag_col_start),
    .m_frag_row_end   (m_frag_row_end),
    .m_frag_col_end   (m_frag_col_end),
    .m_frag_score     (m_frag_score),
    .m_frag_length    (m_frag_length)
);

`default_nettype wire
